// ===== rtl/adtad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adtad_pkg
// shared types, constants and the delta rom of the table audio decoder
// ----------------------------------------------------------------------------
package adtad_pkg;

  localparam int TABLE_SLOTS       = 256;
  localparam int ENTRIES_PER_TABLE = 8;
  localparam int MAX_DEFINED       = 11;
  localparam int STORE_SIZE        = TABLE_SLOTS * ENTRIES_PER_TABLE + MAX_DEFINED + 1;
  localparam int ADDR_W            = $clog2(STORE_SIZE);
  localparam int GROUP_W           = $clog2(ENTRIES_PER_TABLE);

  localparam logic [15:0] MARK        = 16'hFFFF;
  localparam logic [7:0]  OP_DEFINE_LO = 8'hF4;
  localparam logic [7:0]  OP_LITERAL   = 8'hFF;
  localparam logic [7:0]  DEFINE_BIAS  = 8'hF3;
  localparam logic [GROUP_W-1:0] MARK_SLOT = GROUP_W'(5);

  typedef logic [15:0] rom_t [256];

  // fixed point recipe, evaluated at elaboration
  function automatic rom_t build_rom();
    rom_t             r;
    int               pos [128];
    longint unsigned  step;
    longint unsigned  c52;
    longint unsigned  num;
    int               inc;
    logic [31:0]      v;
    step = ((64'd22 << 36) / 64'd10) + 64'd1;
    c52  = ((64'd52 << 36) + 64'd50) / 64'd100;
    pos[0] = 0;
    for (int i = 1; i < 128; i++) begin
      inc = 1;
      num = 64'd105650 - 64'd22 * 64'(i - 1);
      if (i >= 6) begin
        inc = int'((step - c52) >> 36);
      end
      pos[i] = pos[i-1] + inc;
      step = (step * num + 64'd50000) / 64'd100000;
    end
    r[0]   = 16'd0;
    r[128] = 16'd0;
    for (int i = 1; i < 128; i++) begin
      v = 32'(pos[i]) << 1;
      r[128+i] = v[15:0];
      r[128-i] = 16'(32'd0 - v);
    end
    return r;
  endfunction

  localparam rom_t DELTA_ROM = build_rom();

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_INDEX   = 2'd2,
    PH_ENTRIES = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SET_DEFINE,
    OP_SET_BASE,
    OP_WR_ENTRY,
    OP_WR_MARK,
    OP_WALK_BYTE,
    OP_SCAN_STEP,
    OP_EMIT_STEP,
    OP_EMIT_LIT,
    OP_CLR_CTRL,
    OP_CLR_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   phase_we;
    phase_t phase_val;
  } dp_cmd_t;

  typedef struct packed {
    logic   byte_replay;
    logic   byte_literal;
    logic   last;
    phase_t phase;
    logic   entry_done;
    logic   scan_stop;
    logic   walk_empty;
    logic   emit_final;
    logic   out_free;
    logic   clr_done;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/adtad_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adtad_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module adtad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2060
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/adtad_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adtad_ctrl
// sequencer: byte decode, table definition, walk scan and sample emission
// ----------------------------------------------------------------------------
module adtad_ctrl
  import adtad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DECODE   = 11'b000_0000_0100,
    S_LIT      = 11'b000_0000_1000,
    S_WR_ENTRY = 11'b000_0001_0000,
    S_WR_MARK  = 11'b000_0010_0000,
    S_SC_WAIT  = 11'b000_0100_0000,
    S_SC_CHK   = 11'b000_1000_0000,
    S_EM_WAIT  = 11'b001_0000_0000,
    S_EM_OUT   = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.phase_we  = 1'b0;
    cmd.phase_val = PH_OPCODE;
    in_stall      = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR_STEP;
        if (status.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.phase)
          PH_OPCODE: begin
            if (status.byte_replay) begin
              cmd.op     = OP_WALK_BYTE;
              state_next = S_SC_WAIT;
            end else if (status.byte_literal) begin
              cmd.phase_we  = 1'b1;
              cmd.phase_val = PH_LITERAL;
              state_next    = S_FINISH;
            end else begin
              cmd.op        = OP_SET_DEFINE;
              cmd.phase_we  = 1'b1;
              cmd.phase_val = PH_INDEX;
              state_next    = S_FINISH;
            end
          end
          PH_LITERAL: begin
            cmd.phase_we  = 1'b1;
            cmd.phase_val = PH_OPCODE;
            state_next    = S_LIT;
          end
          PH_INDEX: begin
            cmd.op = OP_SET_BASE;
            if (status.last) begin
              state_next = S_WR_MARK;
            end else begin
              cmd.phase_we  = 1'b1;
              cmd.phase_val = PH_ENTRIES;
              state_next    = S_FINISH;
            end
          end
          default: begin
            state_next = S_WR_ENTRY;
          end
        endcase
      end
      S_LIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT_LIT;
          state_next = S_FINISH;
        end
      end
      S_WR_ENTRY: begin
        cmd.op = OP_WR_ENTRY;
        if (status.entry_done) begin
          state_next = S_WR_MARK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WR_MARK: begin
        cmd.op        = OP_WR_MARK;
        cmd.phase_we  = 1'b1;
        cmd.phase_val = PH_OPCODE;
        state_next    = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        state_next = S_SC_CHK;
      end
      S_SC_CHK: begin
        cmd.op = OP_SCAN_STEP;
        if (!status.scan_stop) begin
          state_next = S_SC_WAIT;
        end else if (status.walk_empty) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_EM_WAIT;
        end
      end
      S_EM_WAIT: begin
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT_STEP;
          if (status.emit_final) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_EM_WAIT;
          end
        end
      end
      S_FINISH: begin
        if (status.last) begin
          cmd.op     = OP_CLR_CTRL;
          state_next = S_CLEAR;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/adtad_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adtad_dp
// datapath: decode registers, delta store, predictor, sample output register
// ----------------------------------------------------------------------------
module adtad_dp
  import adtad_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] sample,
  output logic             run_last,
  output logic             run_cut
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  logic [7:0]        byte_r;
  logic              last_r;
  phase_t            phase;
  logic [3:0]        define_count;
  logic [3:0]        entries_received;
  logic [ADDR_W-1:0] table_base;
  logic [31:0]       predictor;
  logic [23:0]       samples_emitted;
  logic [23:0]       sample_limit;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] walk_base;
  logic [RUN_W-1:0]  walked;
  logic [RUN_W-1:0]  emit_idx;
  logic              cut;
  logic [ADDR_W-1:0] clr_cnt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [15:0]       ram_rdata;

  logic [15:0]       rom_delta;
  logic [15:0]       delta;
  logic [31:0]       pred_next;
  logic [23:0]       emitted_inc;
  logic              drop;
  logic              limit_hit;
  logic              is_lit;
  logic              emit_go;
  logic [15:0]       clamped;
  logic [3:0]        er_inc;
  logic [ADDR_W-1:0] byte_base;
  logic              in_range;
  logic              at_mark;
  logic              run_full;
  logic              out_free;

  assign rom_delta = DELTA_ROM[byte_r];
  assign er_inc    = entries_received + 4'd1;
  assign byte_base = ADDR_W'({byte_r, {GROUP_W{1'b0}}});
  assign in_range  = ptr < ADDR_W'(STORE_SIZE);
  assign at_mark   = ram_rdata == MARK;
  assign run_full  = walked == RUN_W'(MAX_RUN);
  assign out_free  = !out_valid || !out_stall;

  // emission arithmetic
  assign is_lit      = cmd.op == OP_EMIT_LIT;
  assign emit_go     = (cmd.op == OP_EMIT_STEP) || is_lit;
  assign delta       = is_lit ? rom_delta : ram_rdata;
  assign pred_next   = predictor + {{16{delta[15]}}, delta};
  assign emitted_inc = samples_emitted + 24'd1;
  assign drop        = (sample_limit != 24'd0) && (samples_emitted >= sample_limit);
  assign limit_hit   = (sample_limit != 24'd0) && (emitted_inc == sample_limit);

  always_comb begin
    if (pred_next[31:15] == {17{pred_next[31]}}) begin
      clamped = pred_next[15:0];
    end else if (pred_next[31]) begin
      clamped = 16'h8000;
    end else begin
      clamped = 16'h7FFF;
    end
  end

  // store write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = 16'd0;
    case (cmd.op)
      OP_CLR_STEP: begin
        ram_we = 1'b1;
        if ((clr_cnt < ADDR_W'(TABLE_SLOTS * ENTRIES_PER_TABLE)) &&
            (clr_cnt[GROUP_W-1:0] == MARK_SLOT)) begin
          ram_wdata = MARK;
        end
      end
      OP_WR_ENTRY: begin
        ram_we    = 1'b1;
        ram_waddr = table_base + ADDR_W'(entries_received);
        ram_wdata = rom_delta;
      end
      OP_WR_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = table_base + ADDR_W'(define_count);
        ram_wdata = MARK;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  adtad_ram #(
    .WIDTH (16),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ptr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit <= 24'd0;
    end else if (cfg_wr_en) begin
      sample_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.op == OP_CLR_CTRL)) begin
      phase            <= PH_OPCODE;
      define_count     <= 4'd0;
      entries_received <= 4'd0;
      table_base       <= '0;
      predictor        <= 32'd0;
      samples_emitted  <= 24'd0;
      clr_cnt          <= '0;
      last_r           <= 1'b0;
    end else begin
      if (cmd.phase_we) begin
        phase <= cmd.phase_val;
      end
      case (cmd.op)
        OP_CAPTURE: begin
          byte_r <= data_byte;
          last_r <= last_byte;
        end
        OP_SET_DEFINE: begin
          define_count <= 4'(byte_r - DEFINE_BIAS);
        end
        OP_SET_BASE: begin
          table_base       <= byte_base;
          entries_received <= 4'd0;
        end
        OP_WR_ENTRY: begin
          entries_received <= er_inc;
        end
        OP_CLR_STEP: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        default: begin
        end
      endcase
      if (emit_go && !drop) begin
        predictor       <= pred_next;
        samples_emitted <= emitted_inc;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walked <= '0;
    end else begin
      case (cmd.op)
        OP_WALK_BYTE: begin
          ptr       <= byte_base;
          walk_base <= byte_base;
          walked    <= '0;
        end
        OP_WR_MARK: begin
          ptr       <= table_base;
          walk_base <= table_base;
          walked    <= '0;
        end
        OP_SCAN_STEP: begin
          if (!in_range || at_mark || run_full) begin
            cut      <= run_full && in_range && !at_mark;
            ptr      <= walk_base;
            emit_idx <= '0;
          end else begin
            ptr    <= ptr + 1'b1;
            walked <= walked + 1'b1;
          end
        end
        OP_EMIT_STEP: begin
          ptr      <= ptr + 1'b1;
          emit_idx <= emit_idx + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go && !drop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go && !drop) begin
      sample   <= $signed(clamped);
      run_last <= is_lit || status.emit_final || limit_hit;
      run_cut  <= !is_lit && cut;
    end
  end

  always_comb begin
    status.byte_replay  = byte_r < OP_DEFINE_LO;
    status.byte_literal = byte_r == OP_LITERAL;
    status.last         = last_r;
    status.phase        = phase;
    status.entry_done   = (er_inc >= define_count) || last_r;
    status.scan_stop    = !in_range || at_mark || run_full;
    status.walk_empty   = walked == '0;
    status.emit_final   = emit_idx == walked - 1'b1;
    status.out_free     = out_free;
    status.clr_done     = clr_cnt == ADDR_W'(STORE_SIZE - 1);
  end

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    walked <= RUN_W'(MAX_RUN))
    else $error("walk length beyond run limit");

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr < ADDR_W'(STORE_SIZE)))
    else $error("store write outside the store");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> out_free)
    else $error("result loaded over a waiting transaction");

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT_STEP) |-> (emit_idx < walked))
    else $error("emission past the end of the walk");
`endif

endmodule
`default_nettype wire

// ===== rtl/adaptive_delta_table_audio_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_delta_table_audio_decoder_top
// body decoder for a delta table compressed audio stream
// ----------------------------------------------------------------------------
// sequence: a byte is captured in S_IDLE and decoded in the next cycle; a
//   replay scans the store (S_SC_WAIT, S_SC_CHK per entry read) then emits
//   each sample (S_EM_WAIT, S_EM_OUT), paced by the single read port of the store
// flow: a new byte is taken only in S_IDLE, once the previous byte is done
// reset: synchronous; a clearing pass writes all 2060 store locations back to
//   their initial pattern after reset and after every last byte, bytes wait
// ----------------------------------------------------------------------------
module adaptive_delta_table_audio_decoder_top
  import adtad_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte transactions
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // sample transactions
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] sample,
  output logic             run_last,
  output logic             run_cut,
  // sample limit register
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer issues one datapath command per cycle
  adtad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // store, predictor and output register
  adtad_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .run_last    (run_last),
    .run_cut     (run_cut)
  );

endmodule
`default_nettype wire
